@@ rtl/assert_macros.svh @@
// assertion helpers used by graph6_edge_decoder_core
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define G6_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define G6_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/g6ed_pkg.sv @@
// shared types and constants of the graph6 edge decoder
// used by g6ed_body and graph6_edge_decoder_core
package g6ed_pkg;

  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_BYTE   = 2'd1,
    ERR_TOO_MANY   = 2'd2,
    ERR_NO_NEWLINE = 2'd3
  } err_e;

  localparam logic [7:0] CH_NUL      = 8'd0;
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_HEADER   = 8'd62;
  localparam logic [7:0] CH_BIAS     = 8'd63;
  localparam logic [7:0] CH_TILDE    = 8'd126;
  localparam logic [3:0] HEADER_SKIP = 4'd9;
  localparam logic [1:0] SIZE_DIGITS = 2'd2;

  // front end to body unit
  typedef struct packed {
    logic       init;  // new count known, restart row tracking
    logic       load;  // body byte accepted
    logic [5:0] bits;  // six body bits, msb first
    logic [6:0] n;     // vertex count for init
  } g6ed_body_ctl_t;

  // body unit to output register
  typedef struct packed {
    logic       valid;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } g6ed_edge_t;

endpackage

@@ rtl/g6ed_body.sv @@
// body decoder: shifts out up to six bits of a body byte, one per
// cycle on advance_i, tracking each bit's (row, column); uses g6ed_pkg
module g6ed_body (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  g6ed_pkg::g6ed_body_ctl_t ctl_i,
  input  logic                     advance_i,
  output g6ed_pkg::g6ed_edge_t     edge_o,
  output logic                     busy_o
);
  import g6ed_pkg::*;

  logic [10:0] total_q, pos_q, avail;
  logic [6:0]  row_q, nm1;
  logic [5:0]  col_q, sh_q, mask;
  logic [2:0]  cnt_q, cap;
  logic [13:0] prod;
  logic        step;

  always_comb begin
    // only bits below n(n-1)/2 are looked at
    avail  = total_q - pos_q;
    cap    = (avail >= 11'd6) ? 3'd6 : avail[2:0];
    mask   = ~(6'h3F >> cap);
    nm1    = (ctl_i.n == 7'd0) ? 7'd0 : ctl_i.n - 7'd1;
    prod   = 14'(ctl_i.n) * 14'(nm1);
    step   = (cnt_q != 3'd0) && advance_i;
    busy_o = (cnt_q != 3'd0);
    edge_o.valid = step && sh_q[5];
    edge_o.row   = row_q[5:0];
    edge_o.col   = col_q;
    edge_o.last  = (sh_q[4:0] == 5'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pos_q   <= '0;
      row_q   <= 7'd1;
      col_q   <= '0;
      sh_q    <= '0;
      cnt_q   <= '0;
    end else if (ctl_i.init) begin
      total_q <= prod[11:1];
      pos_q   <= '0;
      row_q   <= 7'd1;
      col_q   <= '0;
      cnt_q   <= '0;
    end else if (ctl_i.load) begin
      sh_q  <= ctl_i.bits & mask;
      cnt_q <= cap;
    end else if (step) begin
      sh_q  <= {sh_q[4:0], 1'b0};
      cnt_q <= cnt_q - 3'd1;
      pos_q <= pos_q + 11'd1;
      // end of a row: column wraps and the row grows by one
      if (7'(col_q) + 7'd1 == row_q) begin
        row_q <= row_q + 7'd1;
        col_q <= '0;
      end else begin
        col_q <= col_q + 6'd1;
      end
    end
  end

endmodule

@@ rtl/graph6_edge_decoder_core.sv @@
// graph6 edge decoder top level: byte stream in, edge/count/status words out
// uses g6ed_pkg, g6ed_body and assert_macros.svh
//
// Feed one graph6 line, one byte per input word. An optional '>' header of
// ten bytes is skipped, then the vertex count is read from one size byte or
// from '~' and three digits; counts above MAX_VERTICES give an error word.
// Each body byte yields one edge word per set bit, row above column, with
// tlast on the final word a byte causes; a newline gives a done word with
// the count. A body byte is accepted, then the body unit shifts out its
// bits still below n(n-1)/2, up to six, serially; the next byte is taken
// once that shift is done. A full output register that is not taken
// stalls the shift.
module graph6_edge_decoder_core #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] character
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [5:0] edge_row, [11:6] edge_column, [18:12] vertex_count,
  // [20:19] error_code, [23:21] zero
  output logic [g6ed_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [1:0]                         m_axis_tuser,  // [1:0] result_kind
  output logic                               m_axis_tlast   // last
);
  import g6ed_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_HEADER, PH_SIZE, PH_TILDE, PH_DIGITS, PH_BODY, PH_DROP
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [3:0]     hdr_q, hdr_d;
  logic [17:0]    sv_q, sv_d, cand_n;
  logic [1:0]     dig_q, dig_d;
  logic [6:0]     vert_q, vert_d;

  logic           out_valid_q;
  kind_e          kind_q, res_kind;
  err_e           err_q, res_err;
  logic [5:0]     row_q, col_q;
  logic [6:0]     vc_q, res_vc;
  logic           last_q;
  logic           res_valid;

  logic           s_fire, out_free, printable, early, take_count;
  logic [7:0]     ch;
  logic [5:0]     d6;
  g6ed_body_ctl_t ctl;
  g6ed_edge_t     edge_w;
  logic           body_busy;

  assign ch        = s_axis_tdata;
  assign d6        = 6'(ch - CH_BIAS);
  assign printable = (ch >= CH_BIAS) && (ch <= CH_TILDE);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !body_busy && out_free;
  assign s_fire    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_d    = phase_q;
    hdr_d      = hdr_q;
    sv_d       = sv_q;
    dig_d      = dig_q;
    vert_d     = vert_q;
    res_valid  = 1'b0;
    res_kind   = KIND_ERROR;
    res_err    = ERR_NONE;
    res_vc     = '0;
    early      = 1'b0;
    take_count = 1'b0;
    cand_n     = '0;
    ctl        = '0;
    ctl.bits   = d6;
    if (s_fire) begin
      case (phase_q)
        PH_START: begin
          if (ch == CH_HEADER) begin
            hdr_d   = HEADER_SKIP;
            phase_d = PH_HEADER;
          end else if (!printable) begin
            res_valid = 1'b1;
            res_err   = ERR_BAD_BYTE;
            phase_d   = (ch == CH_NEWLINE) ? PH_START : PH_DROP;
          end else if (ch == CH_TILDE) begin
            phase_d = PH_TILDE;
          end else begin
            take_count = 1'b1;
            cand_n     = 18'(d6);
          end
        end
        PH_HEADER: begin
          if (ch == CH_NEWLINE || ch == CH_NUL) begin
            early = 1'b1;
          end else begin
            hdr_d = hdr_q - 4'd1;
            if (hdr_d == 4'd0) phase_d = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (!printable) begin
            early = 1'b1;
          end else if (ch == CH_TILDE) begin
            phase_d = PH_TILDE;
          end else begin
            take_count = 1'b1;
            cand_n     = 18'(d6);
          end
        end
        PH_TILDE: begin
          if (!printable) begin
            early = 1'b1;
          end else if (ch == CH_TILDE) begin
            // a second tilde always means a count far too large
            res_valid = 1'b1;
            res_err   = ERR_TOO_MANY;
            phase_d   = PH_DROP;
          end else begin
            sv_d    = 18'(d6);
            dig_d   = SIZE_DIGITS;
            phase_d = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (!printable) begin
            early = 1'b1;
          end else begin
            sv_d  = {sv_q[11:0], d6};
            dig_d = dig_q - 2'd1;
            if (dig_d == 2'd0) begin
              take_count = 1'b1;
              cand_n     = sv_d;
            end
          end
        end
        PH_BODY: begin
          if (ch == CH_NEWLINE) begin
            res_valid = 1'b1;
            res_kind  = KIND_DONE;
            res_vc    = vert_q;
            phase_d   = PH_START;
          end else if (ch == CH_NUL) begin
            res_valid = 1'b1;
            res_err   = ERR_NO_NEWLINE;
            phase_d   = PH_DROP;
          end else begin
            ctl.load = 1'b1;
          end
        end
        PH_DROP: begin
          if (ch == CH_NEWLINE) phase_d = PH_START;
        end
        default: phase_d = PH_START;
      endcase

      // byte not allowed before the count is known
      if (early) begin
        res_valid = 1'b1;
        if (ch == CH_NEWLINE) begin
          res_err = ERR_BAD_BYTE;
          phase_d = PH_START;
        end else if (ch == CH_NUL) begin
          res_err = ERR_NO_NEWLINE;
          phase_d = PH_DROP;
        end else begin
          res_err = ERR_BAD_BYTE;
          phase_d = PH_DROP;
        end
      end

      if (take_count) begin
        res_valid = 1'b1;
        if (cand_n > 18'(MAX_VERTICES)) begin
          res_err = ERR_TOO_MANY;
          phase_d = PH_DROP;
        end else begin
          res_kind = KIND_COUNT;
          res_vc   = cand_n[6:0];
          vert_d   = cand_n[6:0];
          ctl.init = 1'b1;
          ctl.n    = cand_n[6:0];
          phase_d  = PH_BODY;
        end
      end
    end
  end

  g6ed_body u_body (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .advance_i (out_free),
    .edge_o    (edge_w),
    .busy_o    (body_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      hdr_q       <= '0;
      sv_q        <= '0;
      dig_q       <= '0;
      vert_q      <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_EDGE;
      err_q       <= ERR_NONE;
      row_q       <= '0;
      col_q       <= '0;
      vc_q        <= '0;
      last_q      <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      sv_q    <= sv_d;
      dig_q   <= dig_d;
      vert_q  <= vert_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
        kind_q      <= (res_err == ERR_NONE) ? res_kind : KIND_ERROR;
        err_q       <= res_err;
        row_q       <= '0;
        col_q       <= '0;
        vc_q        <= res_vc;
        last_q      <= 1'b1;
      end else if (edge_w.valid) begin
        out_valid_q <= 1'b1;
        kind_q      <= KIND_EDGE;
        err_q       <= ERR_NONE;
        row_q       <= edge_w.row;
        col_q       <= edge_w.col;
        vc_q        <= '0;
        last_q      <= edge_w.last;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, err_q, vc_q, col_q, row_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

`include "assert_macros.svh"

  `G6_ASSERT_IMPLIES(a_busy_in_body, clk_i, rst_ni, body_busy, phase_q == PH_BODY)
  `G6_ASSERT_IMPLIES(a_edge_below_diag, clk_i, rst_ni, m_axis_tvalid && (kind_q == KIND_EDGE), row_q > col_q)
  `G6_ASSERT_NEXT(a_newline_done, clk_i, rst_ni, s_fire && (phase_q == PH_BODY) && (ch == CH_NEWLINE), m_axis_tvalid && (kind_q == KIND_DONE) && last_q)

endmodule
